// ===== design/msb_first_bit_reader_writer_macros.svh =====
// Assertion macros used by the bit reader/writer checker.
`ifndef MSB_FIRST_BIT_READER_WRITER_MACROS_SVH
`define MSB_FIRST_BIT_READER_WRITER_MACROS_SVH

// same-cycle implication
`define MBRW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MBRW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mbrw_pkg.sv =====
// Package: widths, item kinds and shared types of the bit reader/writer.
package mbrw_pkg;

  localparam int BUFFER_DEPTH = 4096;
  localparam int MAX_BITS     = 32;

  localparam int KIND_W    = 3;
  localparam int CNT_W     = 6;
  localparam int VALUE_W   = 32;
  localparam int BADDR_W   = 12;
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 13;
  localparam int HELD_W    = $clog2(BYTE_W + 1);
  localparam int ADDR_W    = $clog2(BUFFER_DEPTH);
  localparam int PTR_W     = $clog2(BUFFER_DEPTH + 1);

  localparam logic [KIND_W-1:0] KIND_RESTART = 3'd0;
  localparam logic [KIND_W-1:0] KIND_READ    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FLUSH   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LOAD    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FETCH   = 3'd5;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic               status;
  } result_t;

endpackage

// ===== design/mbrw_in_if.sv =====
// Input word channel: item kind and operands.
interface mbrw_in_if;
  logic                          valid;
  logic                          ready;
  logic [mbrw_pkg::KIND_W-1:0]   kind;
  logic [mbrw_pkg::CNT_W-1:0]    bit_count;
  logic [mbrw_pkg::VALUE_W-1:0]  write_value;
  logic [mbrw_pkg::BADDR_W-1:0]  byte_address;
  logic [mbrw_pkg::BYTE_W-1:0]   byte_data;

  modport source (output valid, kind, bit_count, write_value, byte_address, byte_data,
                  input ready);
  modport sink   (input valid, kind, bit_count, write_value, byte_address, byte_data,
                  output ready);
endinterface

// ===== design/mbrw_out_if.sv =====
// Result word channel: read value and status.
interface mbrw_out_if;
  logic                         valid;
  logic                         ready;
  logic [mbrw_pkg::VALUE_W-1:0] read_value;
  logic                         status;

  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

// ===== design/mbrw_cfg_if.sv =====
// Configuration write channel: buffer length register.
interface mbrw_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [mbrw_pkg::LEN_W-1:0] buffer_length;

  modport source (output valid, buffer_length, input ready);
  modport sink   (input valid, buffer_length, output ready);
endinterface

// ===== design/mbrw_ram.sv =====
// Generic single-port RAM with registered read data.
module mbrw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/mbrw_core.sv =====
// Sequencer: cursor state, bit packing and unpacking, byte store access.
module mbrw_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  mbrw_in_if.sink                     in_i,
  input  logic [mbrw_pkg::LEN_W-1:0]  len_i,
  output mbrw_pkg::ram_req_t          ram_req_o,
  input  logic [mbrw_pkg::BYTE_W-1:0] ram_rdata_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output mbrw_pkg::result_t           res_o
);

  localparam int PTR_W   = mbrw_pkg::PTR_W;
  localparam int HELD_W  = mbrw_pkg::HELD_W;
  localparam int CNT_W   = mbrw_pkg::CNT_W;
  localparam int BYTE_W  = mbrw_pkg::BYTE_W;
  localparam int VALUE_W = mbrw_pkg::VALUE_W;
  localparam int ADDR_W  = mbrw_pkg::ADDR_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_WRITE = 3'd2;
  localparam logic [2:0] ST_FETCH = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [PTR_W-1:0]   ptr_q, ptr_d;
  logic [HELD_W-1:0]  held_q, held_d;
  logic [BYTE_W-1:0]  cache_q, cache_d;
  logic [CNT_W-1:0]   left_q, left_d;
  logic [VALUE_W-1:0] acc_q, acc_d;
  logic [VALUE_W-1:0] wv_q, wv_d;
  logic               fetched_q, fetched_d;
  mbrw_pkg::result_t  res_q, res_d;

  logic               take_in;
  logic [PTR_W-1:0]   ulen;
  logic [CNT_W-1:0]   cnt;
  logic               addr_ok;
  logic [BYTE_W-1:0]  src;
  logic [HELD_W-1:0]  h;
  logic [HELD_W-1:0]  take;
  logic [HELD_W-1:0]  rem;
  logic [HELD_W-1:0]  room;
  logic [BYTE_W:0]    one_sh;
  logic [BYTE_W-1:0]  chunk;
  logic [BYTE_W-1:0]  cache_n;
  logic [HELD_W-1:0]  held_n;
  logic [CNT_W-1:0]   left_n;
  logic [VALUE_W-1:0] acc_n;

  assign in_i.ready  = (state_q == ST_IDLE) || ((state_q == ST_EMIT) && res_ready_i);
  assign take_in     = in_i.valid && in_i.ready;
  assign res_valid_o = (state_q == ST_EMIT);
  assign res_o       = res_q;

  always_comb begin
    if (32'(len_i) > mbrw_pkg::BUFFER_DEPTH) begin
      ulen = PTR_W'(mbrw_pkg::BUFFER_DEPTH);
    end else begin
      ulen = PTR_W'(len_i);
    end
    if (32'(in_i.bit_count) > mbrw_pkg::MAX_BITS) begin
      cnt = CNT_W'(mbrw_pkg::MAX_BITS);
    end else begin
      cnt = in_i.bit_count;
    end
    addr_ok = 32'(in_i.byte_address) < mbrw_pkg::BUFFER_DEPTH;
  end

  // read and write step: up to one byte of bits per cycle
  always_comb begin
    src    = fetched_q ? ram_rdata_i : cache_q;
    h      = fetched_q ? HELD_W'(BYTE_W) : held_q;
    room   = HELD_W'(BYTE_W) - held_q;
    take   = '0;
    rem    = '0;
    one_sh = '0;
    chunk  = '0;
    acc_n  = acc_q;
    if (state_q == ST_WRITE) begin
      if (CNT_W'(room) < left_q) begin
        take = room;
      end else begin
        take = left_q[HELD_W-1:0];
      end
      chunk   = wv_q[VALUE_W-1 -: BYTE_W] >> (HELD_W'(BYTE_W) - take);
      cache_n = cache_q | BYTE_W'(chunk << (room - take));
      held_n  = held_q + take;
    end else begin
      if (CNT_W'(h) < left_q) begin
        take = h;
      end else begin
        take = left_q[HELD_W-1:0];
      end
      rem     = h - take;
      one_sh  = (BYTE_W+1)'(1) << rem;
      cache_n = src & BYTE_W'(one_sh - (BYTE_W+1)'(1));
      held_n  = rem;
      if (take != '0) begin
        acc_n = (acc_q << take) | VALUE_W'(src >> rem);
      end
    end
    left_n = left_q - CNT_W'(take);
  end

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    held_d    = held_q;
    cache_d   = cache_q;
    left_d    = left_q;
    acc_d     = acc_q;
    wv_d      = wv_q;
    fetched_d = 1'b0;
    res_d     = res_q;
    ram_req_o = '0;

    unique case (state_q)
      ST_IDLE: begin
      end
      ST_READ: begin
        acc_d   = acc_n;
        left_d  = left_n;
        held_d  = held_n;
        cache_d = cache_n;
        if (left_n == '0) begin
          res_d.read_value = acc_n;
          res_d.status     = 1'b0;
          state_d          = ST_EMIT;
        end else if (ptr_q >= ulen) begin
          res_d   = '0;
          res_d.status = 1'b1;
          state_d = ST_EMIT;
        end else begin
          ram_req_o.addr = ptr_q[ADDR_W-1:0];
          ptr_d          = ptr_q + PTR_W'(1);
          fetched_d      = 1'b1;
        end
      end
      ST_WRITE: begin
        left_d = left_n;
        wv_d   = wv_q << take;
        if (held_n == HELD_W'(BYTE_W)) begin
          held_d  = '0;
          cache_d = '0;
          if (ptr_q < ulen) begin
            ram_req_o.we    = 1'b1;
            ram_req_o.addr  = ptr_q[ADDR_W-1:0];
            ram_req_o.wdata = cache_n;
            ptr_d           = ptr_q + PTR_W'(1);
            if (left_n == '0) begin
              state_d = ST_EMIT;
            end
          end else begin
            res_d.status = 1'b1;
            state_d      = ST_EMIT;
          end
        end else begin
          held_d  = held_n;
          cache_d = cache_n;
          if (left_n == '0) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_FETCH: begin
        res_d.read_value = VALUE_W'(ram_rdata_i);
        res_d.status     = 1'b0;
        state_d          = ST_EMIT;
      end
      ST_EMIT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // dispatch a new word
    if (take_in) begin
      res_d   = '0;
      state_d = ST_EMIT;
      unique case (in_i.kind)
        mbrw_pkg::KIND_RESTART: begin
          ptr_d   = '0;
          held_d  = '0;
          cache_d = '0;
        end
        mbrw_pkg::KIND_READ: begin
          left_d  = cnt;
          acc_d   = '0;
          if (cnt != '0) begin
            state_d = ST_READ;
          end
        end
        mbrw_pkg::KIND_WRITE: begin
          left_d = cnt;
          if (cnt == '0) begin
            wv_d = '0;
          end else begin
            wv_d    = in_i.write_value << (CNT_W'(VALUE_W) - cnt);
            state_d = ST_WRITE;
          end
        end
        mbrw_pkg::KIND_FLUSH: begin
          if (ptr_q < ulen) begin
            ram_req_o.we    = 1'b1;
            ram_req_o.addr  = ptr_q[ADDR_W-1:0];
            ram_req_o.wdata = cache_q;
          end else begin
            res_d.status = 1'b1;
          end
        end
        mbrw_pkg::KIND_LOAD: begin
          if (addr_ok) begin
            ram_req_o.we    = 1'b1;
            ram_req_o.addr  = ADDR_W'(in_i.byte_address);
            ram_req_o.wdata = in_i.byte_data;
          end else begin
            res_d.status = 1'b1;
          end
        end
        mbrw_pkg::KIND_FETCH: begin
          if (addr_ok) begin
            ram_req_o.addr = ADDR_W'(in_i.byte_address);
            state_d        = ST_FETCH;
          end else begin
            res_d.status = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ptr_q     <= '0;
      held_q    <= '0;
      cache_q   <= '0;
      left_q    <= '0;
      fetched_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      held_q    <= held_d;
      cache_q   <= cache_d;
      left_q    <= left_d;
      fetched_q <= fetched_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    wv_q  <= wv_d;
    res_q <= res_d;
  end

endmodule

// ===== design/msb_first_bit_reader_writer.sv =====
// Top level: MSB-first bit reader/writer over a byte store.
//
//  channel  | dir | payload                                                    | accepted when
//  ---------+-----+------------------------------------------------------------+--------------
//  in_i     | in  | kind, bit_count, write_value, byte_address, byte_data      | valid & ready
//  out_o    | out | read_value, status                                         | valid & ready
//  cfg_i    | in  | buffer_length                                              | valid & ready
//
// Restart, flush, load, unused kinds and zero counts go straight to the result, a fetch first
// waits for its store read; a read fetches store bytes one at a time, a write packs its bits into
// the cache byte and stores each byte once it is full, as the store port moves one byte a cycle.
// Reset clears the cursor, the length and the result valid flag; store contents are
// undefined until written. A stalled result waits in the output register; the next
// word is taken in the cycle the pending result moves into it.
module msb_first_bit_reader_writer (
  input  logic        clk_i,
  input  logic        rst_ni,
  mbrw_in_if.sink     in_i,
  mbrw_out_if.source  out_o,
  mbrw_cfg_if.sink    cfg_i
);

  logic [mbrw_pkg::LEN_W-1:0]  len_q;
  mbrw_pkg::ram_req_t          ram_req;
  logic [mbrw_pkg::BYTE_W-1:0] ram_rdata;
  logic                        res_valid;
  logic                        res_ready;
  mbrw_pkg::result_t           res;
  logic                        out_valid_q;
  mbrw_pkg::result_t           out_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_i.valid) begin
      len_q <= cfg_i.buffer_length;
    end
  end

  mbrw_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .len_i       (len_q),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  mbrw_ram #(
    .WIDTH (mbrw_pkg::BYTE_W),
    .DEPTH (mbrw_pkg::BUFFER_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .addr_i  (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .rdata_o (ram_rdata)
  );

  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_value = out_q.read_value;
  assign out_o.status     = out_q.status;

endmodule

// ===== design/mbrw_checker.sv =====
// Port-level checker for the bit reader/writer, bound to the top level.
`include "msb_first_bit_reader_writer_macros.svh"

module mbrw_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [mbrw_pkg::VALUE_W-1:0] out_read_value_i,
  input logic                         out_status_i
);

  logic [1:0] pending_q, pending_d;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    pending_d = pending_q + 2'(in_acc) - 2'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  `MBRW_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_read_value_i) && $stable(out_status_i), "result word changed while stalled")
  `MBRW_ASSERT_NOW(a_no_extra, out_valid_i, pending_q != 2'd0, "result word without an accepted item")
  `MBRW_ASSERT_NOW(a_depth, 1'b1, pending_q != 2'd3, "more than two items in flight")
  `MBRW_ASSERT_NOW(a_fail_zero, out_valid_i && out_status_i, out_read_value_i == '0, "failed item returned data")

endmodule

bind msb_first_bit_reader_writer mbrw_checker u_mbrw_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_read_value_i (out_o.read_value),
  .out_status_i     (out_o.status)
);
